// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TKPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the condition holds at one edge, the consequence must hold at the next.
`define TKPQ_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tkpq_pkg.sv =====
package tkpq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  typedef struct packed {
    logic [7:0]  sev;
    logic [63:0] key;
    logic [31:0] name;
  } entry_t;

  // Best-so-far candidate travelling along the row of cells.
  typedef struct packed {
    logic   valid;
    entry_t ent;
    idx_t   idx;
  } token_t;

  typedef struct packed {
    logic load_new;
    logic shift;
  } cell_ctl_t;

  // True when a is strictly more urgent than b.
  function automatic logic more_urgent(entry_t a, entry_t b);
    if (a.sev != b.sev) begin
      return a.sev > b.sev;
    end
    return a.key < b.key;
  endfunction

endpackage

// ===== hw/rtl/two_key_priority_queue_unit.sv =====
// Priority queue of up to DEPTH entries (64), each a severity, an arrival key and a name
// handle, kept unordered in a row of cells. Insert and remove-at take one transaction and
// finish without a scan; the entry is written into the cell at the fill level, or
// every cell from the removed index upwards takes the entry of its right-hand neighbour in
// one step. Find-next and pop-next send a best-so-far candidate down the row, one cell per
// cycle, so the length of the cell chain sets how long their scan runs;
// a pop then closes the gap in the same cycle as the scan ends. Each result then passes
// to the output register, and one transaction is worked on at a time. The output register
// holds a finished result while the next input transaction is taken. Most urgent means
// highest severity, then the smaller arrival key, then the lower index. Unused result
// fields read as zero.
`include "assert_macros.svh"

module two_key_priority_queue_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [7:0]           new_severity,
  input  logic [63:0]          new_arrival_key,
  input  logic [31:0]          new_name_tag,
  input  tkpq_pkg::idx_t       entry_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output tkpq_pkg::idx_t       found_index,
  output logic [7:0]           out_severity,
  output logic [63:0]          out_arrival_key,
  output logic [31:0]          out_name_tag,
  output tkpq_pkg::cnt_t       entry_count
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HOLD} state_t;

  state_t           state;
  tkpq_pkg::cnt_t   count;
  tkpq_pkg::idx_t   scan_cnt;
  logic             scan_pop;

  // Finished result waiting for the output register.
  logic [1:0]       res_status;
  tkpq_pkg::idx_t   res_found;
  tkpq_pkg::entry_t res_ent;
  tkpq_pkg::cnt_t   res_count;

  tkpq_pkg::entry_t    ents [tkpq_pkg::DEPTH];
  tkpq_pkg::token_t    toks [tkpq_pkg::DEPTH];
  tkpq_pkg::cell_ctl_t ctls [tkpq_pkg::DEPTH];
  logic [tkpq_pkg::DEPTH-1:0] occ;

  tkpq_pkg::entry_t new_entry;
  tkpq_pkg::token_t last_tok;
  logic             accept;
  logic             scan_end;
  logic             ins_do;
  logic             rm_do;
  logic             pop_do;
  logic             shift_do;
  tkpq_pkg::idx_t   shift_idx;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_tok  = toks[tkpq_pkg::DEPTH-1];
  assign new_entry = '{sev: new_severity, key: new_arrival_key, name: new_name_tag};

  // The candidate has passed every cell once the scan counter reaches its top value; the
  // stores do not change while it travels.
  assign scan_end = (state == S_SCAN) &&
                    (scan_cnt == tkpq_pkg::idx_t'(tkpq_pkg::DEPTH - 1));

  assign ins_do   = accept && (opcode == tkpq_pkg::OP_INSERT) &&
                    (count < tkpq_pkg::cnt_t'(tkpq_pkg::DEPTH));
  assign rm_do    = accept && (opcode == tkpq_pkg::OP_REMOVE) &&
                    (tkpq_pkg::cnt_t'(entry_index) < count);
  assign pop_do   = scan_end && scan_pop;
  assign shift_do = rm_do || pop_do;
  assign shift_idx = pop_do ? last_tok.idx : entry_index;

  for (genvar i = 0; i < tkpq_pkg::DEPTH; i++) begin : g_cell
    tkpq_pkg::entry_t right_entry;
    tkpq_pkg::token_t tok_in;

    assign occ[i] = (tkpq_pkg::cnt_t'(i) < count);
    assign ctls[i].load_new = ins_do && (count == tkpq_pkg::cnt_t'(i));
    assign ctls[i].shift    = shift_do &&
                              (tkpq_pkg::cnt_t'(i) >= tkpq_pkg::cnt_t'(shift_idx));

    if (i == tkpq_pkg::DEPTH - 1) begin : g_last
      assign right_entry = ents[i];
    end else begin : g_mid
      assign right_entry = ents[i+1];
    end

    if (i == 0) begin : g_head
      assign tok_in = '0;
    end else begin : g_body
      assign tok_in = toks[i-1];
    end

    tkpq_cell u_cell (
      .clk         (clk),
      .ctl         (ctls[i]),
      .new_entry   (new_entry),
      .right_entry (right_entry),
      .occupied    (occ[i]),
      .cell_idx    (tkpq_pkg::idx_t'(i)),
      .tok_in      (tok_in),
      .ent         (ents[i]),
      .tok         (toks[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_cnt  <= '0;
      scan_pop  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In the hold state the output register is reloaded below instead.
      if (out_valid && !out_stall && (state != S_HOLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_found <= '0;
            res_ent   <= '0;
            unique case (opcode)
              tkpq_pkg::OP_INSERT: begin
                state <= S_HOLD;
                if (ins_do) begin
                  count      <= count + tkpq_pkg::cnt_t'(1);
                  res_count  <= count + tkpq_pkg::cnt_t'(1);
                  res_status <= tkpq_pkg::ST_OK;
                end else begin
                  res_count  <= count;
                  res_status <= tkpq_pkg::ST_FULL;
                end
              end
              tkpq_pkg::OP_REMOVE: begin
                state <= S_HOLD;
                if (rm_do) begin
                  count      <= count - tkpq_pkg::cnt_t'(1);
                  res_count  <= count - tkpq_pkg::cnt_t'(1);
                  res_status <= tkpq_pkg::ST_OK;
                end else begin
                  res_count  <= count;
                  res_status <= tkpq_pkg::ST_BADIDX;
                end
              end
              tkpq_pkg::OP_FIND, tkpq_pkg::OP_POP: begin
                if (count == '0) begin
                  res_count  <= count;
                  res_status <= tkpq_pkg::ST_EMPTY;
                  state      <= S_HOLD;
                end else begin
                  scan_cnt <= '0;
                  scan_pop <= (opcode == tkpq_pkg::OP_POP);
                  state    <= S_SCAN;
                end
              end
              default: begin
                res_count  <= count;
                res_status <= tkpq_pkg::ST_OK;
                state      <= S_HOLD;
              end
            endcase
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + tkpq_pkg::idx_t'(1);
          if (scan_end) begin
            res_status <= tkpq_pkg::ST_OK;
            res_found  <= last_tok.idx;
            state      <= S_HOLD;
            if (scan_pop) begin
              res_ent   <= last_tok.ent;
              count     <= count - tkpq_pkg::cnt_t'(1);
              res_count <= count - tkpq_pkg::cnt_t'(1);
            end else begin
              res_ent   <= '0;
              res_count <= count;
            end
          end
        end
        S_HOLD: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            found_index     <= res_found;
            out_severity    <= res_ent.sev;
            out_arrival_key <= res_ent.key;
            out_name_tag    <= res_ent.name;
            entry_count     <= res_count;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill level never passes the capacity of the row.
  `TKPQ_ASSERT(a_count_bound, count <= tkpq_pkg::cnt_t'(tkpq_pkg::DEPTH), "fill level above capacity")

  // A successful insert raises the fill level by exactly one.
  `TKPQ_ASSERT_NEXT(a_insert_grows, ins_do, count == $past(count) + tkpq_pkg::cnt_t'(1), "insert did not grow the queue")

  // A pop that found an entry lowers the fill level by exactly one.
  `TKPQ_ASSERT_NEXT(a_pop_shrinks, pop_do, count == $past(count) - tkpq_pkg::cnt_t'(1), "pop did not shrink the queue")

  // An empty report always goes with an empty queue.
  `TKPQ_ASSERT(a_empty_count, !(out_valid && (status == tkpq_pkg::ST_EMPTY)) || (entry_count == '0), "empty status with entries left")

endmodule

// ===== hw/rtl/tkpq_cell.sv =====
module tkpq_cell (
  input  logic                clk,
  input  tkpq_pkg::cell_ctl_t ctl,
  input  tkpq_pkg::entry_t    new_entry,
  input  tkpq_pkg::entry_t    right_entry,
  input  logic                occupied,
  input  tkpq_pkg::idx_t      cell_idx,
  input  tkpq_pkg::token_t    tok_in,
  output tkpq_pkg::entry_t    ent,
  output tkpq_pkg::token_t    tok
);

  tkpq_pkg::token_t tok_next;

  // The incoming candidate wins ties, since it always comes from a lower index.
  always_comb begin
    tok_next = tok_in;
    if (occupied && (!tok_in.valid || tkpq_pkg::more_urgent(ent, tok_in.ent))) begin
      tok_next.valid = 1'b1;
      tok_next.ent   = ent;
      tok_next.idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      ent <= new_entry;
    end else if (ctl.shift) begin
      ent <= right_entry;
    end
    tok <= tok_next;
  end

endmodule

// ===== test/testbench.sv =====
// Checks the two-key priority queue against a behavioural copy kept alongside it.
// Every accepted input transaction is applied to the local copy of the queue. The
// result it produces is then queued, and each result transaction that leaves the
// block is compared field by field with the oldest queued result.
module testbench;

  // One predicted result transaction, laid out like the block's result ports.
  typedef struct packed {
    logic [1:0]     status;
    tkpq_pkg::idx_t found;
    logic [7:0]     sev;
    logic [63:0]    key;
    logic [31:0]    name;
    tkpq_pkg::cnt_t count;
  } outcome_t;

  logic           clk = 1'b0;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  logic [1:0]     opcode;
  logic [7:0]     new_severity;
  logic [63:0]    new_arrival_key;
  logic [31:0]    new_name_tag;
  tkpq_pkg::idx_t entry_index;
  logic           out_valid;
  logic           out_stall;
  logic [1:0]     status;
  tkpq_pkg::idx_t found_index;
  logic [7:0]     out_severity;
  logic [63:0]    out_arrival_key;
  logic [31:0]    out_name_tag;
  tkpq_pkg::cnt_t entry_count;

  // Local copy of the queue contents, in the block's own slot order.
  logic [7:0]  held_sev [tkpq_pkg::DEPTH];
  logic [63:0] held_key [tkpq_pkg::DEPTH];
  logic [31:0] held_name [tkpq_pkg::DEPTH];
  int          held_count;

  outcome_t    pending_outcomes [$];
  outcome_t    oldest;
  int          error_count;
  logic        idle_enable;
  int          stall_left;
  bit          filling;

  two_key_priority_queue_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .new_severity    (new_severity),
    .new_arrival_key (new_arrival_key),
    .new_name_tag    (new_name_tag),
    .entry_index     (entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .found_index     (found_index),
    .out_severity    (out_severity),
    .out_arrival_key (out_arrival_key),
    .out_name_tag    (out_name_tag),
    .entry_count     (entry_count)
  );

  always #2 clk = ~clk;

  // Scans the stored entries for the most urgent one. Severity decides first, then
  // the smaller arrival key; a full tie keeps the earlier slot because only a
  // strictly more urgent entry replaces the current best.
  function automatic int most_urgent_slot();
    int best;
    int i;
    best = 0;
    for (i = 1; i < held_count; i++) begin
      if (held_sev[i] > held_sev[best] ||
          (held_sev[i] == held_sev[best] && held_key[i] < held_key[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Deletes one slot and moves every later entry down by one place.
  function automatic void close_gap(input int at);
    int i;
    for (i = at; i < held_count - 1; i++) begin
      held_sev[i]  = held_sev[i + 1];
      held_key[i]  = held_key[i + 1];
      held_name[i] = held_name[i + 1];
    end
    held_count--;
  endfunction

  // Applies one accepted request to the local queue and returns the result the block
  // must give for it. Fields with no meaning for the operation stay zero.
  function automatic outcome_t apply_request(input logic [1:0] op, input logic [7:0] sev,
                                             input logic [63:0] key, input logic [31:0] name,
                                             input tkpq_pkg::idx_t idx);
    outcome_t res;
    int       pick;
    res = '0;
    res.status = tkpq_pkg::ST_OK;
    case (op)
      tkpq_pkg::OP_INSERT: begin
        if (held_count >= tkpq_pkg::DEPTH) begin
          res.status = tkpq_pkg::ST_FULL;
        end else begin
          held_sev[held_count]  = sev;
          held_key[held_count]  = key;
          held_name[held_count] = name;
          held_count++;
        end
      end
      tkpq_pkg::OP_FIND: begin
        if (held_count == 0) begin
          res.status = tkpq_pkg::ST_EMPTY;
        end else begin
          res.found = tkpq_pkg::idx_t'(most_urgent_slot());
        end
      end
      tkpq_pkg::OP_REMOVE: begin
        if (int'(idx) >= held_count) begin
          res.status = tkpq_pkg::ST_BADIDX;
        end else begin
          close_gap(int'(idx));
        end
      end
      default: begin
        if (held_count == 0) begin
          res.status = tkpq_pkg::ST_EMPTY;
        end else begin
          pick = most_urgent_slot();
          res.found = tkpq_pkg::idx_t'(pick);
          res.sev   = held_sev[pick];
          res.key   = held_key[pick];
          res.name  = held_name[pick];
          close_gap(pick);
        end
      end
    endcase
    res.count = tkpq_pkg::cnt_t'(held_count);
    return res;
  endfunction

  // Prints one line per mismatch and counts every one of them.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Result checker. Outputs are read at the rising edge, before any of that edge's
  // updates land, so this sees exactly what the block itself sees when deciding
  // whether the result transaction completes.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding", 64'd0, 64'd0);
      end else begin
        oldest = pending_outcomes.pop_front();
        compare_field("status", 64'(status), 64'(oldest.status));
        compare_field("found_index", 64'(found_index), 64'(oldest.found));
        compare_field("out_severity", 64'(out_severity), 64'(oldest.sev));
        compare_field("out_arrival_key", out_arrival_key, oldest.key);
        compare_field("out_name_tag", 64'(out_name_tag), 64'(oldest.name));
        compare_field("entry_count", 64'(entry_count), 64'(oldest.count));
      end
    end
  end

  // Receiver back-pressure: random bursts of stalled cycles while idling is allowed.
  // A burst that has started always runs to its end.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one request and returns at the edge where the block takes it. Valid is left
  // high, so the next call either keeps it high or opens a gap; it is never lowered
  // and raised within one time step. The request is applied to the local queue at the
  // moment of acceptance, which keeps the prediction in transaction order.
  task automatic send_request(input logic [1:0] op, input logic [7:0] sev,
                              input logic [63:0] key, input logic [31:0] name,
                              input tkpq_pkg::idx_t idx);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= op;
    new_severity    <= sev;
    new_arrival_key <= key;
    new_name_tag    <= name;
    entry_index     <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(apply_request(op, sev, key, name, idx));
  endtask

  // Severities are often drawn from a tiny set so that ties on the first key are
  // common and the arrival key has to decide.
  function automatic logic [7:0] pick_severity();
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, 3));
    end
    return 8'($urandom);
  endfunction

  // Arrival keys: a tiny pool for full ties, fully random values, or a packed prefix
  // with zero padding in the low bytes as a short time string would give.
  function automatic logic [63:0] pick_arrival_key();
    case ($urandom_range(0, 2))
      0:       return 64'($urandom_range(0, 3));
      1:       return {$urandom, $urandom};
      default: return {$urandom, 32'd0};
    endcase
  endfunction

  // Removal index: mostly a stored slot, sometimes any value so that bad indexes
  // keep turning up.
  function automatic tkpq_pkg::idx_t pick_slot();
    if (held_count > 0 && $urandom_range(0, 5) != 0) begin
      return tkpq_pkg::idx_t'($urandom_range(0, held_count - 1));
    end
    return tkpq_pkg::idx_t'($urandom_range(0, tkpq_pkg::DEPTH - 1));
  endfunction

  // One random request. The mix swings between a filling phase, which runs the queue
  // up to full, and a draining phase, which runs it down to empty, so that both
  // boundaries and every fill level in between are visited many times.
  task automatic send_random_request();
    int         roll;
    logic [1:0] op;
    if (held_count >= tkpq_pkg::DEPTH) begin
      filling = 1'b0;
    end else if (held_count == 0) begin
      filling = 1'b1;
    end
    roll = $urandom_range(0, 99);
    if (roll < (filling ? 65 : 22)) begin
      op = tkpq_pkg::OP_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0:       op = tkpq_pkg::OP_FIND;
        1:       op = tkpq_pkg::OP_REMOVE;
        default: op = tkpq_pkg::OP_POP;
      endcase
    end
    send_request(op, pick_severity(), pick_arrival_key(), $urandom, pick_slot());
  endtask

  // All but insert on an empty queue: both searches report empty and a removal at
  // either end of the index range reports a bad index.
  task automatic check_empty_queue();
    send_request(tkpq_pkg::OP_FIND, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_POP, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0,
                 tkpq_pkg::idx_t'(tkpq_pkg::DEPTH - 1));
  endtask

  // Field extremes, both tie-breaks, and removals at the ends and in the middle.
  task automatic check_field_extremes();
    send_request(tkpq_pkg::OP_INSERT, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_INSERT, 8'hFF, '1, '1, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_INSERT, 8'hFF, 64'd0, 32'h1234_5678, tkpq_pkg::idx_t'(0));
    // Equal severity: the smaller arrival key must win.
    send_request(tkpq_pkg::OP_FIND, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_POP, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    // A second entry identical in both keys: the lower slot must win.
    send_request(tkpq_pkg::OP_INSERT, 8'hFF, '1, 32'hA5A5_A5A5, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_FIND, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0,
                 tkpq_pkg::idx_t'(tkpq_pkg::DEPTH - 1));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(3));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    // "08:30:00" against "08:30" with zero padding; the shorter string sorts first.
    send_request(tkpq_pkg::OP_INSERT, 8'd9, 64'h3038_3A33_303A_3030, 32'h0000_0001,
                 tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_INSERT, 8'd9, 64'h3038_3A33_3000_0000, 32'h0000_0002,
                 tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(1));
    send_request(tkpq_pkg::OP_POP, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_POP, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_POP, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
  endtask

  // Fills the queue to capacity, presses on against a full queue, works on the
  // highest slot, then drains it completely and pops once more on empty.
  task automatic check_fill_to_full();
    while (held_count < tkpq_pkg::DEPTH) begin
      send_request(tkpq_pkg::OP_INSERT, pick_severity(), pick_arrival_key(), $urandom,
                   tkpq_pkg::idx_t'(0));
    end
    repeat (3) begin
      send_request(tkpq_pkg::OP_INSERT, pick_severity(), pick_arrival_key(), $urandom,
                   tkpq_pkg::idx_t'(0));
    end
    send_request(tkpq_pkg::OP_FIND, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0,
                 tkpq_pkg::idx_t'(tkpq_pkg::DEPTH - 1));
    send_request(tkpq_pkg::OP_INSERT, pick_severity(), pick_arrival_key(), $urandom,
                 tkpq_pkg::idx_t'(0));
    send_request(tkpq_pkg::OP_POP, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
    while (held_count > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(tkpq_pkg::OP_REMOVE, 8'd0, 64'd0, 32'd0,
                     tkpq_pkg::idx_t'($urandom_range(0, held_count - 1)));
      end else begin
        send_request(tkpq_pkg::OP_POP, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
      end
    end
    send_request(tkpq_pkg::OP_POP, 8'd0, 64'd0, 32'd0, tkpq_pkg::idx_t'(0));
  endtask

  // Random traffic with idling on both sides, broken by stretches with none.
  task automatic check_mixed_traffic(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        idle_enable = ($urandom_range(0, 3) != 0);
      end
      send_random_request();
    end
  endtask

  // The last part of the run goes back to back, with neither side idling.
  task automatic check_quiet_tail(input int count);
    idle_enable = 1'b0;
    repeat (count) send_random_request();
  endtask

  initial begin
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    opcode          <= tkpq_pkg::OP_INSERT;
    new_severity    <= 8'd0;
    new_arrival_key <= 64'd0;
    new_name_tag    <= 32'd0;
    entry_index     <= tkpq_pkg::idx_t'(0);
    idle_enable     <= 1'b1;
    held_count      = 0;
    error_count     = 0;
    filling         = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    check_empty_queue();
    check_field_extremes();
    check_fill_to_full();
    check_mixed_traffic(380);
    check_quiet_tail(110);

    // Let every outstanding result arrive, then wait a full scan longer so that a
    // stray extra result would still be caught.
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (tkpq_pkg::DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tkpq_pkg.sv
hw/rtl/tkpq_cell.sv
hw/rtl/two_key_priority_queue_unit.sv
test/testbench.sv
